// ===== hw/rtl/bpq_pkg.sv =====
package bpq_pkg;

	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam int PRIO_W   = 32;
	localparam int LIMIT_W  = 5;
	localparam int COUNT_W  = 5;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic REG_MAX_ENTRIES = 1'b0;

	localparam logic [LIMIT_W-1:0] MAX_ENTRIES_RST = 5'd16;

	typedef logic signed [PRIO_W-1:0] prio_t;

	typedef struct packed {
		logic ins;
		logic rem;
	} bpq_ctl_t;

endpackage

// ===== hw/rtl/bpq_cell.sv =====
module bpq_cell #(
	parameter int TAG_WIDTH = 16
) (
	input  logic                 clk,
	input  bpq_pkg::bpq_ctl_t    ctl,
	input  logic                 occupied,
	input  bpq_pkg::prio_t       new_prio,
	input  logic [TAG_WIDTH-1:0] new_tag,
	input  logic                 left_keep,
	input  bpq_pkg::prio_t       left_prio,
	input  logic [TAG_WIDTH-1:0] left_tag,
	input  bpq_pkg::prio_t       right_prio,
	input  logic [TAG_WIDTH-1:0] right_tag,
	output logic                 keep,
	output bpq_pkg::prio_t       prio,
	output logic [TAG_WIDTH-1:0] tag,
	output logic [TAG_WIDTH-1:0] tag_next
);
	import bpq_pkg::*;

	prio_t                prio_q;
	logic [TAG_WIDTH-1:0] tag_q;
	prio_t                prio_d;
	logic [TAG_WIDTH-1:0] tag_d;

	// entry stays put when it ranks at or above the new one
	assign keep = occupied && (prio_q >= new_prio);

	always_comb begin
		prio_d = prio_q;
		tag_d  = tag_q;
		priority if (ctl.ins) begin
			if (keep) begin
				prio_d = prio_q;
				tag_d  = tag_q;
			end else if (left_keep) begin
				prio_d = new_prio;
				tag_d  = new_tag;
			end else begin
				prio_d = left_prio;
				tag_d  = left_tag;
			end
		end else if (ctl.rem) begin
			prio_d = right_prio;
			tag_d  = right_tag;
		end
	end

	always_ff @(posedge clk) begin
		prio_q <= prio_d;
		tag_q  <= tag_d;
	end

	assign prio     = prio_q;
	assign tag      = tag_q;
	assign tag_next = tag_d;

endmodule

// ===== hw/rtl/bounded_priority_queue.sv =====
// bounded priority queue, sorted by descending signed priority
// input channel (in_valid/in_ready): opcode, priority_req, task_tag;
//   opcode insert places the entry behind all entries of greater or equal
//   priority, opcode remove drops the head entry
// output channel (out_valid/out_ready): one result beat per input beat:
//   ok, head_valid, head_tag, count, empty_res, all after the operation
// storage is a row of CAPACITY cells; every cell compares its entry with
//   the new priority and takes its own, the new or a neighbor's entry in
//   the same cycle, so the whole row is updated together
// the result is registered and shows in the cycle after acceptance
// throughput: one beat per cycle while the receiver takes each result
// a stalled receiver holds the result; the next input beat is taken in the
//   cycle the result is taken, and none while it waits
// apb register 0 (byte address 0): max_entries, 5 bits, reset 16
// reset empties the queue and clears the output valid; cell contents are
//   not cleared and are only read below the count
module bounded_priority_queue #(
	parameter int CAPACITY  = 16,
	parameter int TAG_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bpq_pkg::PADDR_W-1:0]    paddr,
	input  logic [bpq_pkg::PDATA_W-1:0]    pwdata,
	output logic [bpq_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           opcode,
	input  logic signed [bpq_pkg::PRIO_W-1:0] priority_req,
	input  logic [TAG_WIDTH-1:0]           task_tag,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           ok,
	output logic                           head_valid,
	output logic [TAG_WIDTH-1:0]           head_tag,
	output logic [bpq_pkg::COUNT_W-1:0]    count,
	output logic                           empty_res
);
	import bpq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
	localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

	logic [LIMIT_W-1:0]   max_entries_q;
	logic [CW-1:0]        count_q;
	logic                 out_valid_q;
	logic                 ok_q;
	logic                 head_valid_q;
	logic [COUNT_W-1:0]   count_res_q;
	logic [TAG_WIDTH-1:0] head_tag_q;

	logic                 accept;
	logic                 cfg_wr;
	logic [LW-1:0]        max_l;
	logic [LW-1:0]        limit;
	logic [LW-1:0]        count_l;
	logic                 op_ok;
	logic [CW-1:0]        count_d;
	logic [LW-1:0]        count_d_l;
	bpq_ctl_t             ctl;

	logic                 keep     [CAPACITY];
	prio_t                cprio    [CAPACITY];
	logic [TAG_WIDTH-1:0] ctag     [CAPACITY];
	logic [TAG_WIDTH-1:0] ctag_nx  [CAPACITY];

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[PADDR_W-1] == REG_MAX_ENTRIES);
	assign prdata = (paddr[PADDR_W-1] == REG_MAX_ENTRIES)
		? PDATA_W'(max_entries_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= MAX_ENTRIES_RST;
		end else if (cfg_wr) begin
			max_entries_q <= pwdata[LIMIT_W-1:0];
		end
	end

	// operation control
	assign accept  = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;
	assign max_l   = LW'(max_entries_q);
	assign limit   = (max_l < CAP_L) ? max_l : CAP_L;
	assign count_l = LW'(count_q);

	always_comb begin
		unique case (opcode)
			OP_INSERT: op_ok = count_l < limit;
			OP_REMOVE: op_ok = count_q != '0;
			default:   op_ok = 1'b0;
		endcase
	end

	assign ctl.ins = accept && (opcode == OP_INSERT) && op_ok;
	assign ctl.rem = accept && (opcode == OP_REMOVE) && op_ok;

	always_comb begin
		count_d = count_q;
		priority if (ctl.ins) begin
			count_d = count_q + CW'(1);
		end else if (ctl.rem) begin
			count_d = count_q - CW'(1);
		end
	end
	assign count_d_l = LW'(count_d);

	// cell row, head at cell 0
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                 lk;
		prio_t                lp;
		logic [TAG_WIDTH-1:0] lt;
		prio_t                rp;
		logic [TAG_WIDTH-1:0] rt;

		if (i == 0) begin : g_head
			assign lk = 1'b1;
			assign lp = priority_req;
			assign lt = task_tag;
		end else begin : g_mid
			assign lk = keep[i-1];
			assign lp = cprio[i-1];
			assign lt = ctag[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign rp = '0;
			assign rt = '0;
		end else begin : g_body
			assign rp = cprio[i+1];
			assign rt = ctag[i+1];
		end

		bpq_cell #(
			.TAG_WIDTH(TAG_WIDTH)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occupied   (CW'(i) < count_q),
			.new_prio   (priority_req),
			.new_tag    (task_tag),
			.left_keep  (lk),
			.left_prio  (lp),
			.left_tag   (lt),
			.right_prio (rp),
			.right_tag  (rt),
			.keep       (keep[i]),
			.prio       (cprio[i]),
			.tag        (ctag[i]),
			.tag_next   (ctag_nx[i])
		);
	end

	// count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			out_valid_q  <= 1'b0;
			ok_q         <= 1'b0;
			head_valid_q <= 1'b0;
			count_res_q  <= '0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				out_valid_q  <= 1'b1;
				ok_q         <= op_ok;
				head_valid_q <= count_d != '0;
				count_res_q  <= count_d_l[COUNT_W-1:0];
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			head_tag_q <= (count_d != '0) ? ctag_nx[0] : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign ok         = ok_q;
	assign head_valid = head_valid_q;
	assign head_tag   = head_tag_q;
	assign count      = count_res_q;
	assign empty_res  = !head_valid_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_l <= CAP_L)
		else $error("count above capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> count_q == $past(count_q) + CW'(1))
		else $error("accepted insert did not grow the count");

	a_head_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> head_valid_q == (count_q != '0))
		else $error("result head flag disagrees with count");
`endif

endmodule

// ===== verif/bounded_priority_queue_tb.sv =====
`timescale 1ns / 1ps

module bounded_priority_queue_tb;

	import bpq_pkg::*;

	localparam int DEPTH      = 16;
	localparam int TAG_W      = 16;
	localparam int IDLE_LIMIT = 2000;
	localparam logic [PADDR_W-1:0] LIMIT_ADDR = PADDR_W'(4 * REG_MAX_ENTRIES);

	typedef struct {
		logic             op;
		prio_t            prio;
		logic [TAG_W-1:0] tag;
	} queue_op_t;

	typedef struct packed {
		logic               ok;
		logic               head_valid;
		logic [TAG_W-1:0]   head_tag;
		logic [COUNT_W-1:0] count;
		logic               empty;
	} queue_status_t;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]   pwdata;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	logic                 in_valid;
	logic                 in_ready;
	logic                 opcode;
	prio_t                priority_req;
	logic [TAG_W-1:0]     task_tag;
	logic                 out_valid;
	logic                 out_ready;
	logic                 ok;
	logic                 head_valid;
	logic [TAG_W-1:0]     head_tag;
	logic [COUNT_W-1:0]   count;
	logic                 empty_res;

	// shadow copy of the sorted storage
	prio_t            shadow_prio [DEPTH];
	logic [TAG_W-1:0] shadow_tag [DEPTH];
	int               shadow_count;
	int               shadow_limit;

	queue_op_t     op_backlog[$];
	queue_status_t expected_status[$];

	int   beats_queued;
	int   beats_taken;
	int   errors;
	int   idle_cycles;
	int   gap_left;
	int   stall_left;
	logic in_taken;
	logic out_taken;
	logic calm_in;
	logic calm_out;

	int phase_limit [10] = '{31, 16, 1, 0, 2, 17, 5, 16, 8, -1};
	int phase_ins_pct [10] = '{70, 80, 50, 35, 65, 85, 55, 60, 75, 60};

	bounded_priority_queue #(
		.CAPACITY (DEPTH),
		.TAG_WIDTH(TAG_W)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.priority_req(priority_req),
		.task_tag    (task_tag),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.ok          (ok),
		.head_valid  (head_valid),
		.head_tag    (head_tag),
		.count       (count),
		.empty_res   (empty_res)
	);

	always #6 clk = ~clk;

	function automatic queue_status_t predict_status(queue_op_t it);
		queue_status_t s;
		int lim;
		int pos;
		int i;
		lim = (shadow_limit < DEPTH) ? shadow_limit : DEPTH;
		s.ok = 1'b0;
		if (it.op == OP_INSERT) begin
			if (shadow_count < lim) begin
				pos = 0;
				while (pos < shadow_count && shadow_prio[pos] >= it.prio)
					pos++;
				for (i = shadow_count; i > pos; i--) begin
					shadow_prio[i] = shadow_prio[i-1];
					shadow_tag[i]  = shadow_tag[i-1];
				end
				shadow_prio[pos] = it.prio;
				shadow_tag[pos]  = it.tag;
				shadow_count++;
				s.ok = 1'b1;
			end
		end else if (shadow_count > 0) begin
			for (i = 1; i < shadow_count; i++) begin
				shadow_prio[i-1] = shadow_prio[i];
				shadow_tag[i-1]  = shadow_tag[i];
			end
			shadow_count--;
			s.ok = 1'b1;
		end
		s.head_valid = (shadow_count > 0);
		s.head_tag   = (shadow_count > 0) ? shadow_tag[0] : '0;
		s.count      = COUNT_W'(shadow_count);
		s.empty      = (shadow_count == 0);
		return s;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// mostly short gaps, some long ones, none while calm
	function automatic int pick_gap(logic calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic void push_op(logic op, prio_t prio, logic [TAG_W-1:0] tag);
		queue_op_t it;
		it.op   = op;
		it.prio = prio;
		it.tag  = tag;
		op_backlog.push_back(it);
		beats_queued++;
	endfunction

	function automatic void push_random(int ins_pct);
		prio_t p;
		int    r;
		r = $urandom_range(0, 9);
		if (r < 4)
			p = prio_t'(int'($urandom_range(0, 6)) - 3);
		else if (r < 8)
			p = prio_t'($urandom);
		else if (r == 8)
			p = 32'sh7fff_ffff;
		else
			p = 32'sh8000_0000;
		push_op(($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE, p,
			TAG_W'($urandom));
	endfunction

	task automatic drain_queue();
		do
			@(negedge clk);
		while (beats_taken != beats_queued || expected_status.size() != 0);
		repeat (2) @(negedge clk);
	endtask

	// apb write followed by a readback of the limit register
	task automatic write_limit(int unsigned val);
		logic [PDATA_W-1:0] word;
		word = ($urandom & ~32'h1f) | (val & 32'h1f);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= LIMIT_ADDR;
		pwdata  <= word;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		pwdata  <= $urandom;
		shadow_limit = int'(word[LIMIT_W-1:0]);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		check_field("max_entries", {27'b0, word[LIMIT_W-1:0]}, prdata);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// driver
	always @(negedge clk) begin
		queue_op_t it;
		if (!(in_valid && !in_taken)) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (op_backlog.size() > 0) begin
				it = op_backlog.pop_front();
				in_valid     <= 1'b1;
				opcode       <= it.op;
				priority_req <= it.prio;
				task_tag     <= it.tag;
				if ($urandom_range(0, 39) == 0)
					calm_in = !calm_in;
				gap_left = pick_gap(calm_in);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (out_taken) begin
			if ($urandom_range(0, 39) == 0)
				calm_out = !calm_out;
			stall_left = pick_gap(calm_out);
		end
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		queue_op_t     it;
		queue_status_t want;
		in_taken  = in_valid && in_ready;
		out_taken = out_valid && out_ready;
		if (out_taken) begin
			if (expected_status.size() == 0) begin
				errors++;
				$display("%0t ns: result beat with nothing expected, expected none, actual %0h",
					$time, {ok, head_valid, head_tag, count, empty_res});
			end else begin
				want = expected_status.pop_front();
				check_field("ok", 32'(want.ok), 32'(ok));
				check_field("head_valid", 32'(want.head_valid), 32'(head_valid));
				check_field("head_tag", 32'(want.head_tag), 32'(head_tag));
				check_field("count", 32'(want.count), 32'(count));
				check_field("empty_res", 32'(want.empty), 32'(empty_res));
			end
		end
		if (in_taken) begin
			it.op   = opcode;
			it.prio = priority_req;
			it.tag  = task_tag;
			expected_status.push_back(predict_status(it));
			beats_taken++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		int lim;
		clk          = 1'b0;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		in_valid     = 1'b0;
		opcode       = OP_INSERT;
		priority_req = '0;
		task_tag     = '0;
		out_ready    = 1'b0;
		shadow_count = 0;
		shadow_limit = int'(MAX_ENTRIES_RST);
		beats_queued = 0;
		beats_taken  = 0;
		errors       = 0;
		idle_cycles  = 0;
		gap_left     = 0;
		stall_left   = 0;
		in_taken     = 1'b0;
		out_taken    = 1'b0;
		calm_in      = 1'b0;
		calm_out     = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// ordering, ties, extremes, remove on empty
		push_op(OP_REMOVE, 32'sh7fff_ffff, 16'hffff);
		push_op(OP_INSERT, 32'sd0, 16'h0001);
		push_op(OP_INSERT, 32'sh7fff_ffff, 16'hffff);
		push_op(OP_INSERT, 32'sh8000_0000, 16'h0000);
		push_op(OP_INSERT, -32'sd1, 16'h1234);
		push_op(OP_INSERT, 32'sh7fff_ffff, 16'h0002);
		push_op(OP_INSERT, 32'sd0, 16'h0003);
		push_op(OP_REMOVE, 32'sh8000_0000, 16'haaaa);
		push_op(OP_REMOVE, -32'sd1, 16'h5555);
		drain_queue();

		// limit below the held count
		write_limit(1);
		push_op(OP_INSERT, 32'sd5, 16'h0bad);
		push_op(OP_REMOVE, 32'sd0, 16'h0000);
		push_op(OP_REMOVE, 32'sd0, 16'h0000);
		push_op(OP_REMOVE, 32'sd0, 16'h0000);
		push_op(OP_INSERT, 32'sd9, 16'h0bee);
		push_op(OP_REMOVE, 32'sd0, 16'h0000);
		push_op(OP_INSERT, 32'sd7, 16'h00c1);
		push_op(OP_INSERT, 32'sd8, 16'h00c2);
		drain_queue();

		// zero limit
		write_limit(0);
		push_op(OP_INSERT, 32'sh7fff_ffff, 16'hffff);
		push_op(OP_REMOVE, 32'sd0, 16'h0000);
		push_op(OP_REMOVE, 32'sd0, 16'h0000);
		push_op(OP_INSERT, 32'sd1, 16'h0001);
		drain_queue();

		for (int ph = 0; ph < 10; ph++) begin
			lim = (phase_limit[ph] < 0) ? $urandom_range(0, 31) : phase_limit[ph];
			write_limit(lim);
			repeat (105) push_random(phase_ins_pct[ph]);
			drain_queue();
		end

		repeat (4) @(posedge clk);
		if (expected_status.size() != 0)
			errors++;
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
